// File: hdl/pauli_string_multiply_core_defines.svh
// ---------------------------------------------------------------------------
// Pauli string multiply assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PAULI_STRING_MULTIPLY_CORE_DEFINES_SVH
`define PAULI_STRING_MULTIPLY_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/psm_pkg.sv
// ---------------------------------------------------------------------------
// Pauli string multiply package
// Word types, widths and defaults shared by the product core and its lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psm_pkg;

  localparam int unsigned PSM_WIDTH      = 64;
  localparam int unsigned PSM_QUBITS_DEF = 64;
  localparam int unsigned PSM_LANE_W     = 8;

  typedef struct packed {
    logic [PSM_WIDTH-1:0] a_xbits;
    logic [PSM_WIDTH-1:0] a_zbits;
    logic [1:0]           a_phase;
    logic [PSM_WIDTH-1:0] b_xbits;
    logic [PSM_WIDTH-1:0] b_zbits;
    logic [1:0]           b_phase;
  } psm_req_t;

  typedef struct packed {
    logic [PSM_WIDTH-1:0] prod_xbits;
    logic [PSM_WIDTH-1:0] prod_zbits;
    logic [1:0]           prod_phase;
    logic                 commutes;
  } psm_rsp_t;

endpackage

// File: hdl/psm_lane.sv
// ---------------------------------------------------------------------------
// Pauli string multiply lane
// Counts anticommuting and negative-sign positions over one slice of qubits
// and returns their phase contribution, anti + 2 * neg, modulo 4.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psm_lane #(
  parameter int unsigned LANE_W = psm_pkg::PSM_LANE_W
) (
  input  logic [LANE_W-1:0] a_x,
  input  logic [LANE_W-1:0] a_z,
  input  logic [LANE_W-1:0] b_x,
  input  logic [LANE_W-1:0] b_z,
  output logic [1:0]        contrib
);
  import psm_pkg::*;

  logic [LANE_W-1:0] anti;
  logic [LANE_W-1:0] neg;

  assign anti = (a_x & b_z) ^ (a_z & b_x);
  assign neg  = anti & (a_x ^ (b_z & (a_z | b_x)));

  always_comb begin
    logic [1:0] acc;
    acc = 2'd0;
    for (int i = 0; i < LANE_W; i++) begin
      acc = acc + {1'b0, anti[i]} + {neg[i], 1'b0};
    end
    contrib = acc;
  end

endmodule

// File: hdl/psm_merge.sv
// ---------------------------------------------------------------------------
// Pauli string multiply merge
// Adds the lane contributions to the operand phases modulo 4 and derives
// the commutation flag from the parity of the anticommuting count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psm_merge #(
  parameter int unsigned LANES = 8
) (
  input  logic [LANES-1:0][1:0] contrib,
  input  logic [1:0]            base_phase,
  output logic [1:0]            prod_phase,
  output logic                  commutes
);
  import psm_pkg::*;

  logic [1:0] lane_sum;

  always_comb begin
    logic [1:0] acc;
    acc = 2'd0;
    for (int l = 0; l < LANES; l++) begin
      acc = acc + contrib[l];
    end
    lane_sum = acc;
  end

  assign prod_phase = base_phase + lane_sum;
  assign commutes   = ~lane_sum[0];

endmodule

// File: hdl/pauli_string_multiply_core.sv
// ---------------------------------------------------------------------------
// Pauli string multiply core
// An accepted request word is registered in the lane-count stage, then in the merged-result stage.
// Throughput: one word per cycle while rsp_ready does not stall; lanes of eight qubits count in parallel.
// Two registered stages (lane counts, merged result) stall together.
// Reset clears both stage valid flags; payload registers are not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pauli_string_multiply_core_defines.svh"

module pauli_string_multiply_core #(
  parameter int unsigned QUBITS = psm_pkg::PSM_QUBITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  psm_pkg::psm_req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output psm_pkg::psm_rsp_t rsp
);
  import psm_pkg::*;

  localparam int unsigned LANES = (QUBITS + PSM_LANE_W - 1) / PSM_LANE_W;
  localparam int unsigned SPAN  = LANES * PSM_LANE_W;
  localparam logic [PSM_WIDTH-1:0] QMASK =
    (QUBITS >= PSM_WIDTH) ? {PSM_WIDTH{1'b1}}
                          : ((PSM_WIDTH)'(1) << QUBITS) - (PSM_WIDTH)'(1);

  logic [PSM_WIDTH-1:0] ax, az, bx, bz;
  logic [SPAN-1:0]      ax_pad, az_pad, bx_pad, bz_pad;
  logic [LANES-1:0][1:0] lane_contrib;

  logic                  s1_valid;
  logic [PSM_WIDTH-1:0]  s1_xbits;
  logic [PSM_WIDTH-1:0]  s1_zbits;
  logic [1:0]            s1_phase;
  logic [LANES-1:0][1:0] s1_contrib;
  logic                  s1_adv;

  logic [1:0] merge_phase;
  logic       merge_commutes;

  assign ax = req.a_xbits & QMASK;
  assign az = req.a_zbits & QMASK;
  assign bx = req.b_xbits & QMASK;
  assign bz = req.b_zbits & QMASK;

  assign ax_pad = SPAN'(ax);
  assign az_pad = SPAN'(az);
  assign bx_pad = SPAN'(bx);
  assign bz_pad = SPAN'(bz);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    psm_lane #(
      .LANE_W(PSM_LANE_W)
    ) u_lane (
      .a_x    (ax_pad[l*PSM_LANE_W +: PSM_LANE_W]),
      .a_z    (az_pad[l*PSM_LANE_W +: PSM_LANE_W]),
      .b_x    (bx_pad[l*PSM_LANE_W +: PSM_LANE_W]),
      .b_z    (bz_pad[l*PSM_LANE_W +: PSM_LANE_W]),
      .contrib(lane_contrib[l])
    );
  end

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_xbits   <= ax ^ bx;
      s1_zbits   <= az ^ bz;
      s1_phase   <= req.a_phase + req.b_phase;
      s1_contrib <= lane_contrib;
    end
  end

  psm_merge #(
    .LANES(LANES)
  ) u_merge (
    .contrib   (s1_contrib),
    .base_phase(s1_phase),
    .prod_phase(merge_phase),
    .commutes  (merge_commutes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.prod_xbits <= s1_xbits;
      rsp.prod_zbits <= s1_zbits;
      rsp.prod_phase <= merge_phase;
      rsp.commutes   <= merge_commutes;
    end
  end

  `PSM_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, s1_valid, "accepted word lost")
  `PSM_ASSERT_NEXT(a_s1_moves_out, s1_adv, rsp_valid, "stage one word not delivered")
  `PSM_ASSERT_SAME(a_stall_only_full, !req_ready, s1_valid && rsp_valid && !rsp_ready,
                   "request stalled while pipeline has room")
  `PSM_ASSERT_SAME(a_upper_zero, rsp_valid,
                   ((rsp.prod_xbits | rsp.prod_zbits) & ~QMASK) == '0,
                   "product bits set above qubit count")

endmodule
